FILE: rtl/interval_timer_three_channel_assert.svh
// assertion macros shared by the timer checker
// no dependencies
`ifndef INTERVAL_TIMER_THREE_CHANNEL_ASSERT_SVH
`define INTERVAL_TIMER_THREE_CHANNEL_ASSERT_SVH
// implication checked on every clock edge outside reset
`define ITT_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("timer check failed");
// next-cycle implication outside reset
`define ITT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("timer check failed");
`endif

FILE: rtl/itt_pkg.sv
// package for the three-channel interval timer: codes, types and constants
// no dependencies
`default_nettype none
package itt_pkg;
  localparam int unsigned NumChannels = 3;
  localparam int unsigned CountWidth = 20;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_GATE    = 2'd2,
    OP_ADVANCE = 2'd3
  } op_t;

  localparam logic [1:0] PORT_CONTROL = 2'd3;

  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LSB   = 2'd1;
  localparam logic [1:0] ACC_MSB   = 2'd2;
  localparam logic [1:0] ACC_BOTH  = 2'd3;

  // one queued command
  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  port;
    logic [7:0]  data;
    logic [15:0] ticks;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic       is_out_event;
    logic [1:0] out_channel;
    logic       out_level;
    logic       last;
  } res_t;
endpackage
`default_nettype wire

FILE: rtl/itt_front.sv
// front end: two-entry command queue
// depends on itt_pkg
`default_nettype none
module itt_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire itt_pkg::cmd_t in_cmd,
  output logic              q_valid,
  input  wire logic         q_ready,
  output itt_pkg::cmd_t     q_cmd
);
  itt_pkg::cmd_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/itt_back.sv
// back end: channel state, one command per cycle unless result beats wait,
// results to an output register; depends on itt_pkg
`default_nettype none
module itt_back #(
  parameter int unsigned NUM_CHANNELS = itt_pkg::NumChannels,
  parameter int unsigned COUNT_WIDTH  = itt_pkg::CountWidth
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire itt_pkg::cmd_t q_cmd,
  output logic               res_valid,
  input  wire logic          res_ready,
  output itt_pkg::res_t      res
);
  localparam int unsigned W = COUNT_WIDTH;

  logic signed [W-1:0] cnt      [NUM_CHANNELS];
  logic [15:0]         reload   [NUM_CHANNELS];
  logic [15:0]         hold     [NUM_CHANNELS];
  logic [15:0]         latched  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] lvalid, bcd, lownext, pend, run, gate, outl;
  logic [2:0]          mode     [NUM_CHANNELS];
  logic [1:0]          acc      [NUM_CHANNELS];

  logic signed [W-1:0] cnt_next [NUM_CHANNELS];
  logic [15:0]         reload_next [NUM_CHANNELS];
  logic [15:0]         hold_next [NUM_CHANNELS];
  logic [15:0]         latched_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] lvalid_next, bcd_next, lownext_next, pend_next;
  logic [NUM_CHANNELS-1:0] run_next, gate_next, outl_next;
  logic [2:0]          mode_next [NUM_CHANNELS];
  logic [1:0]          acc_next  [NUM_CHANNELS];

  // result staging: up to three beats
  itt_pkg::res_t       rbuf [3];
  logic [1:0]          rcnt;
  logic [1:0]          ridx;
  itt_pkg::res_t       nres [3];
  logic [1:0]          ncnt;
  logic                busy;
  logic                take;

  assign busy      = (rcnt != 2'd0);
  assign q_ready   = !busy || (res_ready && (ridx == rcnt - 2'd1));
  assign take      = q_valid && q_ready;
  assign res_valid = busy;
  assign res       = rbuf[ridx];

  // execute one command
  always_comb begin
    logic [1:0] sel, rl;
    logic [2:0] md;
    logic [7:0] rbyte;
    logic       low, g;
    logic [15:0] rv;
    logic signed [W+1:0] c, dec;
    logic signed [W+1:0] floorv;
    int unsigned ch;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      cnt_next[i] = cnt[i];   reload_next[i] = reload[i];
      hold_next[i] = hold[i]; latched_next[i] = latched[i];
      mode_next[i] = mode[i]; acc_next[i] = acc[i];
    end
    lvalid_next = lvalid; bcd_next = bcd; lownext_next = lownext;
    pend_next = pend; run_next = run; gate_next = gate; outl_next = outl;
    for (int k = 0; k < 3; k++) nres[k] = '0;
    ncnt   = 2'd0;
    sel    = q_cmd.data[7:6];
    rl     = q_cmd.data[5:4];
    md     = q_cmd.data[3:1];
    rbyte  = 8'd0;
    low    = 1'b0;
    g      = q_cmd.data[0];
    rv     = 16'd0;
    c      = '0;
    dec    = '0;
    floorv = -(signed'({{(W+1){1'b0}}, 1'b1} <<< (W-1)));
    ch     = 0;
    unique case (q_cmd.op)
      itt_pkg::OP_WRITE: begin
        if (q_cmd.port == itt_pkg::PORT_CONTROL) begin
          if (sel != 2'd3 && 32'(sel) < NUM_CHANNELS) begin
            ch = 32'(sel);
            if (rl == itt_pkg::ACC_LATCH) begin
              latched_next[ch] = cnt[ch][15:0];
              lvalid_next[ch] = 1'b1; lownext_next[ch] = 1'b1; pend_next[ch] = 1'b0;
            end else begin
              mode_next[ch] = (md >= 3'd6) ? {1'b0, md[1:0]} : md;
              bcd_next[ch] = q_cmd.data[0];
              acc_next[ch] = rl;
              pend_next[ch] = 1'b1;
              if (rl == itt_pkg::ACC_BOTH) lownext_next[ch] = 1'b1;
            end
          end
        end else if (32'(q_cmd.port) < NUM_CHANNELS) begin
          ch = 32'(q_cmd.port);
          low = (acc[ch] == itt_pkg::ACC_LSB) ||
                (acc[ch] == itt_pkg::ACC_BOTH && lownext[ch]);
          if (acc[ch] == itt_pkg::ACC_BOTH) lownext_next[ch] = ~lownext[ch];
          if (low) begin
            hold_next[ch] = {hold[ch][15:8], q_cmd.data};
          end else begin
            rv = {q_cmd.data, hold[ch][7:0]};
            hold_next[ch] = rv;
            reload_next[ch] = rv;
            if (pend[ch]) begin
              cnt_next[ch] = signed'(W'(rv - 16'd1));
              pend_next[ch] = 1'b0;
            end
          end
          if (outl[ch] != (mode[ch] != 3'd0)) begin
            outl_next[ch] = (mode[ch] != 3'd0);
            nres[0] = '{8'd0, 1'b1, 2'(ch), outl_next[ch], 1'b1};
            ncnt = 2'd1;
          end
        end
      end
      itt_pkg::OP_READ: begin
        if (32'(q_cmd.port) < NUM_CHANNELS && q_cmd.port != itt_pkg::PORT_CONTROL) begin
          ch = 32'(q_cmd.port);
          rv = lvalid[ch] ? latched[ch] : cnt[ch][15:0];
          low = (acc[ch] == itt_pkg::ACC_LSB) ||
                (acc[ch] == itt_pkg::ACC_BOTH && lownext[ch]);
          if (acc[ch] == itt_pkg::ACC_BOTH) lownext_next[ch] = ~lownext[ch];
          if (low) rbyte = rv[7:0];
          else begin
            rbyte = rv[15:8];
            lvalid_next[ch] = 1'b0;
          end
        end
        nres[0] = '{rbyte, 1'b0, 2'd0, 1'b0, 1'b1};
        ncnt = 2'd1;
      end
      itt_pkg::OP_GATE: begin
        if (32'(q_cmd.port) < NUM_CHANNELS && q_cmd.port != itt_pkg::PORT_CONTROL) begin
          ch = 32'(q_cmd.port);
          if (mode[ch] == 3'd0 || mode[ch] == 3'd2 || mode[ch] == 3'd3) run_next[ch] = g;
          else if ((mode[ch] == 3'd1 || mode[ch] == 3'd5) && !gate[ch] && g)
            run_next[ch] = 1'b1;
          if ((mode[ch] == 3'd2 || mode[ch] == 3'd3) && !g && !outl[ch]) begin
            outl_next[ch] = 1'b1;
            nres[0] = '{8'd0, 1'b1, 2'(ch), 1'b1, 1'b1};
            ncnt = 2'd1;
          end
          if (!gate[ch] && g) cnt_next[ch] = signed'(W'(reload[ch]));
          gate_next[ch] = g;
        end
      end
      default: begin
        // advance time, channels in order
        if (q_cmd.ticks != 16'd0) begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (run[i]) begin
              if (mode[i] >= 3'd4 && !outl[i]) begin
                outl_next[i] = 1'b1;
                run_next[i] = 1'b0;
                cnt_next[i] = signed'(W'(17'd65535));
              end else begin
                dec = signed'((W+2)'(q_cmd.ticks));
                if (mode[i] == 3'd3) dec = dec <<< 1;
                c = (W+2)'(cnt[i]) - dec;
                if (c < floorv) c = floorv;
                if (c <= 0) begin
                  c = c + ((reload[i] == 16'd0) ? (W+2)'(65536) : (W+2)'(reload[i]));
                  if (mode[i] == 3'd0 || mode[i] == 3'd1) outl_next[i] = 1'b1;
                  else if (mode[i] == 3'd2) outl_next[i] = 1'b0;
                  else if (mode[i] == 3'd3) outl_next[i] = ~outl[i];
                end else begin
                  if (mode[i] == 3'd1 || mode[i] == 3'd4 || mode[i] == 3'd5)
                    outl_next[i] = 1'b0;
                  else if (mode[i] == 3'd2) outl_next[i] = 1'b1;
                end
                cnt_next[i] = c[W-1:0];
              end
              if (outl_next[i] != outl[i]) begin
                nres[ncnt] = '{8'd0, 1'b1, 2'(i), outl_next[i], 1'b0};
                ncnt = ncnt + 2'd1;
              end
            end
          end
          if (ncnt != 2'd0) nres[ncnt - 2'd1].last = 1'b1;
        end
      end
    endcase
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt[i] <= '0; reload[i] <= '0; hold[i] <= '0; latched[i] <= '0;
        mode[i] <= 3'd3; acc[i] <= itt_pkg::ACC_BOTH;
      end
      lvalid <= '0; bcd <= '0; lownext <= '1; pend <= '0;
      run <= '0; gate <= '0; outl <= '0;
    end else if (take) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt[i] <= cnt_next[i]; reload[i] <= reload_next[i];
        hold[i] <= hold_next[i]; latched[i] <= latched_next[i];
        mode[i] <= mode_next[i]; acc[i] <= acc_next[i];
      end
      lvalid <= lvalid_next; bcd <= bcd_next; lownext <= lownext_next;
      pend <= pend_next; run <= run_next; gate <= gate_next; outl <= outl_next;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < 3; k++) rbuf[k] <= nres[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= 2'd0;
      ridx <= 2'd0;
    end else if (take) begin
      rcnt <= ncnt;
      ridx <= 2'd0;
    end else if (busy && res_ready) begin
      if (ridx == rcnt - 2'd1) begin
        rcnt <= 2'd0;
        ridx <= 2'd0;
      end else begin
        ridx <= ridx + 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/interval_timer_three_channel.sv
// top level of the three-channel interval timer
// depends on itt_pkg, itt_front, itt_back
//
// channel  dir  tdata (low bit up)                 tuser/tlast
// s_axis   in   operation, port, data, tick_count  -
// m_axis   out  read_data, out_channel, out_level  tuser is_out_event, tlast last
//
// a command executes in the back end when it is taken; 0 to 3 result beats follow
// one per cycle while m_axis_tready is high, and the next command is taken with the last beat
// a two-entry queue lets the input take up to two beats while results stall
// synchronous reset brings every channel to mode 3, lsb/msb access, count zero
`default_nettype none
module interval_timer_three_channel #(
  parameter int unsigned NUM_CHANNELS = itt_pkg::NumChannels,
  parameter int unsigned COUNT_WIDTH  = itt_pkg::CountWidth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // operation, port, data, tick_count
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // read_data, out_channel, out_level, zero pad
  output logic             m_axis_tuser,  // is_out_event
  output logic             m_axis_tlast
);
  itt_pkg::cmd_t in_cmd, q_cmd;
  itt_pkg::res_t res;
  logic          q_valid, q_ready;

  assign in_cmd = '{s_axis_tdata[1:0], s_axis_tdata[3:2], s_axis_tdata[11:4],
                    s_axis_tdata[27:12]};

  itt_front u_front (
    .clk, .rst,
    .in_valid (s_axis_tvalid), .in_ready (s_axis_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  itt_back #(.NUM_CHANNELS(NUM_CHANNELS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .res_valid (m_axis_tvalid), .res_ready (m_axis_tready), .res
  );

  assign m_axis_tdata = {5'd0, res.out_level, res.out_channel, res.read_data};
  assign m_axis_tuser = res.is_out_event;
  assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

FILE: rtl/itt_checker.sv
// port-level checks for the interval timer, bound to the top level
// depends on interval_timer_three_channel_assert.svh
`default_nettype none
`include "interval_timer_three_channel_assert.svh"
module itt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);
  // a read beat carries no channel or level
  `ITT_ASSERT_IMPL(a_read_clean, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[10:8] == 3'd0)
  // an event beat carries no read byte
  `ITT_ASSERT_IMPL(a_event_clean, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[7:0] == 8'd0)
  // event channel in range
  `ITT_ASSERT_IMPL(a_chan_range, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[9:8] != 2'd3)
  // a read result is always the only beat of its item
  `ITT_ASSERT_IMPL(a_read_last, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
  // a stalled beat holds
  `ITT_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind interval_timer_three_channel itt_checker u_checker (.*);
`default_nettype wire
